// File: src/gds_pkg.sv
// shared types, constants and calendar helper functions for the date stepper
package gds_pkg;

  localparam int STEP_COUNT_BITS_DEF = 16;
  localparam int COUNT_PORT_W        = 16;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // floor(2^20 / 100) and floor(2^10 / 7), quotients come out exact or one low
  localparam logic [13:0] DIV100_K = 14'd10485;
  localparam int          DIV100_S = 20;
  localparam logic [7:0]  DIV7_K   = 8'd146;
  localparam int          DIV7_S   = 10;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_BACK = 2'd2;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_CAP_LOAD = 4'd1;
  localparam logic [3:0] OP_CAP_STEP = 4'd2;
  localparam logic [3:0] OP_CAP_NONE = 4'd3;
  localparam logic [3:0] OP_YR_MUL   = 4'd4;
  localparam logic [3:0] OP_YR_SPLIT = 4'd5;
  localparam logic [3:0] OP_MON_ADJ  = 4'd6;
  localparam logic [3:0] OP_DAY_SET  = 4'd7;
  localparam logic [3:0] OP_DAY_ADJ  = 4'd8;
  localparam logic [3:0] OP_STEP     = 4'd9;
  localparam logic [3:0] OP_SUM      = 4'd10;
  localparam logic [3:0] OP_MUL7     = 4'd11;
  localparam logic [3:0] OP_OUT      = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic       dir_back;
  } dp_ctrl_t;

  // leap test from year split as century and year within century
  function automatic logic leap_of(input logic [6:0] lo, input logic [6:0] hi);
    logic res;
    if (lo == 7'd0) begin
      res = (hi[1:0] == 2'd0);
    end else begin
      res = (lo[1:0] == 2'd0);
    end
    return res;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] res;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: res = 5'd30;
      4'd2:                    res = leap ? 5'd29 : 5'd28;
      default:                 res = 5'd31;
    endcase
    return res;
  endfunction

  // (13 * (m + 1)) / 5 with january and february counted as months 13 and 14
  function automatic logic [5:0] zel_month_term(input logic [3:0] m);
    logic [5:0] res;
    case (m)
      4'd1:    res = 6'd36;
      4'd2:    res = 6'd39;
      4'd3:    res = 6'd10;
      4'd4:    res = 6'd13;
      4'd5:    res = 6'd15;
      4'd6:    res = 6'd18;
      4'd7:    res = 6'd20;
      4'd8:    res = 6'd23;
      4'd9:    res = 6'd26;
      4'd10:   res = 6'd28;
      4'd11:   res = 6'd31;
      4'd12:   res = 6'd33;
      default: res = 6'd0;
    endcase
    return res;
  endfunction

endpackage

// File: src/gregorian_date_stepper.sv
// a load runs LMUL, LSPLIT, LMON, LDAY, LADJ, SUM, MUL7 and DONE, a step runs STEP, SUM, MUL7, DONE
// and command 3 runs SUM, MUL7, DONE; the stepper moves one day per cycle till the count is zero
// one item at a time: the next beat is taken the cycle after the result enters the output register
// a held result does not block the next item, only the final handoff of that item waits
// synchronous reset gives 2000-01-01, leap year, month length 31, no result pending
module gregorian_date_stepper import gds_pkg::*; #(
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              command,
  input  logic [4:0]              new_day,
  input  logic [3:0]              new_month,
  input  logic [13:0]             new_year,
  input  logic [COUNT_PORT_W-1:0] step_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [4:0]              day,
  output logic [3:0]              month,
  output logic [13:0]             year,
  output logic [2:0]              weekday,
  output logic                    is_leap,
  output logic [4:0]              month_length,
  output logic                    range_error
);

  dp_ctrl_t ctrl;
  logic     days_zero;

  gds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .days_zero (days_zero),
    .ctrl      (ctrl)
  );

  gds_datapath #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .days_zero    (days_zero),
    .new_day      (new_day),
    .new_month    (new_month),
    .new_year     (new_year),
    .step_count   (step_count),
    .day          (day),
    .month        (month),
    .year         (year),
    .weekday      (weekday),
    .is_leap      (is_leap),
    .month_length (month_length),
    .range_error  (range_error)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while an item is in progress");

  a_date_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (day <= month_length))
    else $error("result date out of range");

  a_year_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (year >= YEAR_MIN) && (year <= YEAR_MAX) && (weekday <= 3'd6))
    else $error("result year or weekday out of range");

  a_len_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month_length == month_len(month, is_leap))
    else $error("month length disagrees with month and leap flag");

endmodule

// File: src/gds_datapath.sv
// date registers, single-day step logic, year split and weekday arithmetic
module gds_datapath import gds_pkg::*; #(
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_ctrl_t                ctrl,
  output logic                    days_zero,
  input  logic [4:0]              new_day,
  input  logic [3:0]              new_month,
  input  logic [13:0]             new_year,
  input  logic [COUNT_PORT_W-1:0] step_count,
  output logic [4:0]              day,
  output logic [3:0]              month,
  output logic [13:0]             year,
  output logic [2:0]              weekday,
  output logic                    is_leap,
  output logic [4:0]              month_length,
  output logic                    range_error
);

  localparam logic [1:0] ADJ_NONE = 2'd0;
  localparam logic [1:0] ADJ_BACK = 2'd1;
  localparam logic [1:0] ADJ_FWD  = 2'd2;

  logic [4:0]                 cur_day;
  logic [3:0]                 cur_month;
  logic [13:0]                cur_year;
  logic [6:0]                 year_lo;
  logic [6:0]                 year_hi;
  logic [STEP_COUNT_BITS-1:0] days_left;
  logic                       err_flag;
  logic [4:0]                 ld_day;
  logic [3:0]                 ld_month;
  logic [1:0]                 adj;
  logic [27:0]                prod;
  logic [9:0]                 hsum;
  logic [17:0]                prod7;

  logic [31:0] cnt_ext;
  logic [13:0] year_cl;
  logic        cl_err;
  logic        leap_cur;
  logic [4:0]  len_cur;

  // month forward and backward candidates
  logic        mf_ok, mb_ok;
  logic [3:0]  mf_month, mb_month;
  logic [13:0] mf_year, mb_year;
  logic [6:0]  mf_lo, mf_hi, mb_lo, mb_hi;
  logic [4:0]  mb_len;

  // selected move for this cycle
  logic        mv_en, mv_day_op, mv_back;
  logic        mv_fail;
  logic [4:0]  mv_day;
  logic [3:0]  mv_month;
  logic [13:0] mv_year;
  logic [6:0]  mv_lo, mv_hi;

  logic [6:0]  q0;
  logic [14:0] r0;
  logic        jan_feb;
  logic [6:0]  zk, zj;
  logic [7:0]  q7;
  logic [9:0]  r7;

  assign cnt_ext   = 32'(step_count);
  assign days_zero = (days_left == '0);
  assign cl_err    = (new_year == 14'd0) || (new_year > YEAR_MAX);
  assign year_cl   = (new_year == 14'd0) ? YEAR_MIN : ((new_year > YEAR_MAX) ? YEAR_MAX : new_year);
  assign leap_cur  = leap_of(year_lo, year_hi);
  assign len_cur   = month_len(cur_month, leap_cur);

  always_comb begin
    mf_ok    = !((cur_month >= 4'd12) && (cur_year >= YEAR_MAX));
    mf_month = cur_month + 4'd1;
    mf_year  = cur_year;
    mf_lo    = year_lo;
    mf_hi    = year_hi;
    if (cur_month >= 4'd12) begin
      mf_month = 4'd1;
      mf_year  = cur_year + 14'd1;
      if (year_lo == 7'd99) begin
        mf_lo = 7'd0;
        mf_hi = year_hi + 7'd1;
      end else begin
        mf_lo = year_lo + 7'd1;
      end
    end
    mb_ok    = !((cur_month <= 4'd1) && (cur_year <= YEAR_MIN));
    mb_month = cur_month - 4'd1;
    mb_year  = cur_year;
    mb_lo    = year_lo;
    mb_hi    = year_hi;
    if (cur_month <= 4'd1) begin
      mb_month = 4'd12;
      mb_year  = cur_year - 14'd1;
      if (year_lo == 7'd0) begin
        mb_lo = 7'd99;
        mb_hi = year_hi - 7'd1;
      end else begin
        mb_lo = year_lo - 7'd1;
      end
    end
    mb_len = month_len(mb_month, leap_of(mb_lo, mb_hi));
  end

  // which move the current operation asks for
  always_comb begin
    mv_en     = 1'b0;
    mv_day_op = 1'b1;
    mv_back   = 1'b0;
    case (ctrl.op)
      OP_MON_ADJ: begin
        mv_en     = (ld_month == 4'd0) || (ld_month > 4'd12);
        mv_day_op = 1'b0;
        mv_back   = (ld_month == 4'd0);
      end
      OP_DAY_ADJ: begin
        mv_en   = (adj != ADJ_NONE);
        mv_back = (adj == ADJ_BACK);
      end
      OP_STEP: begin
        mv_en   = !days_zero;
        mv_back = ctrl.dir_back;
      end
      default: begin
        mv_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    mv_day   = cur_day;
    mv_month = cur_month;
    mv_year  = cur_year;
    mv_lo    = year_lo;
    mv_hi    = year_hi;
    mv_fail  = 1'b0;
    if (!mv_back) begin
      if (mv_day_op && (cur_day < len_cur)) begin
        mv_day = cur_day + 5'd1;
      end else if (!mf_ok) begin
        mv_fail = 1'b1;
      end else begin
        mv_month = mf_month;
        mv_year  = mf_year;
        mv_lo    = mf_lo;
        mv_hi    = mf_hi;
        if (mv_day_op) begin
          mv_day = 5'd1;
        end
      end
    end else begin
      if (mv_day_op && (cur_day > 5'd1)) begin
        mv_day = cur_day - 5'd1;
      end else if (!mb_ok) begin
        mv_fail = 1'b1;
      end else begin
        mv_month = mb_month;
        mv_year  = mb_year;
        mv_lo    = mb_lo;
        mv_hi    = mb_hi;
        if (mv_day_op) begin
          mv_day = mb_len;
        end
      end
    end
  end

  // year split from the reciprocal product, one correction step
  assign q0 = prod[DIV100_S+6:DIV100_S];
  assign r0 = {1'b0, cur_year} - 15'(15'(q0) * 15'd100);

  // zeller terms, january and february belong to the year before
  always_comb begin
    jan_feb = (cur_month <= 4'd2);
    zk      = year_lo;
    zj      = year_hi;
    if (jan_feb) begin
      if (year_lo == 7'd0) begin
        zk = 7'd99;
        zj = year_hi - 7'd1;
      end else begin
        zk = year_lo - 7'd1;
      end
    end
  end

  assign q7 = prod7[DIV7_S+7:DIV7_S];
  assign r7 = hsum - 10'(10'(q7) * 10'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= 5'd1;
      cur_month <= 4'd1;
      cur_year  <= 14'd2000;
      year_lo   <= 7'd0;
      year_hi   <= 7'd20;
      days_left <= '0;
      err_flag  <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_CAP_LOAD: begin
          cur_year <= year_cl;
          err_flag <= cl_err;
        end
        OP_CAP_STEP: begin
          days_left <= cnt_ext[STEP_COUNT_BITS-1:0];
          err_flag  <= 1'b0;
        end
        OP_CAP_NONE: begin
          err_flag <= 1'b0;
        end
        OP_YR_SPLIT: begin
          if (r0 >= 15'd100) begin
            year_lo <= 7'(r0 - 15'd100);
            year_hi <= q0 + 7'd1;
          end else begin
            year_lo <= 7'(r0);
            year_hi <= q0;
          end
          if (ld_month == 4'd0) begin
            cur_month <= 4'd1;
          end else if (ld_month > 4'd12) begin
            cur_month <= 4'd12;
          end else begin
            cur_month <= ld_month;
          end
        end
        OP_DAY_SET: begin
          if (ld_day == 5'd0) begin
            cur_day <= 5'd1;
          end else if (ld_day > len_cur) begin
            cur_day <= len_cur;
          end else begin
            cur_day <= ld_day;
          end
        end
        OP_MON_ADJ, OP_DAY_ADJ, OP_STEP: begin
          if (mv_en) begin
            if (mv_fail) begin
              err_flag  <= 1'b1;
              days_left <= '0;
            end else begin
              cur_day   <= mv_day;
              cur_month <= mv_month;
              cur_year  <= mv_year;
              year_lo   <= mv_lo;
              year_hi   <= mv_hi;
              if (ctrl.op == OP_STEP) begin
                days_left <= days_left - (STEP_COUNT_BITS)'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload-only registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_CAP_LOAD: begin
        ld_day   <= new_day;
        ld_month <= new_month;
      end
      OP_YR_MUL: begin
        prod <= 28'(cur_year) * 28'(DIV100_K);
      end
      OP_DAY_SET: begin
        if (ld_day == 5'd0) begin
          adj <= ADJ_BACK;
        end else if (ld_day > len_cur) begin
          adj <= ADJ_FWD;
        end else begin
          adj <= ADJ_NONE;
        end
      end
      OP_SUM: begin
        hsum <= 10'(cur_day) + 10'(zel_month_term(cur_month)) + 10'(zk) + 10'(zk >> 2)
                + 10'(zj >> 2) + 10'(10'(zj) * 10'd5);
      end
      OP_MUL7: begin
        prod7 <= 18'(hsum) * 18'(DIV7_K);
      end
      OP_OUT: begin
        day          <= cur_day;
        month        <= cur_month;
        year         <= cur_year;
        weekday      <= (r7 >= 10'd7) ? 3'(r7 - 10'd7) : 3'(r7);
        is_leap      <= leap_cur;
        month_length <= len_cur;
        range_error  <= err_flag;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/gds_ctrl.sv
// sequencer for load, day stepping, weekday calculation and result handoff
module gds_ctrl import gds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic       days_zero,
  output dp_ctrl_t   ctrl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LMUL   = 4'd1;
  localparam logic [3:0] S_LSPLIT = 4'd2;
  localparam logic [3:0] S_LMON   = 4'd3;
  localparam logic [3:0] S_LDAY   = 4'd4;
  localparam logic [3:0] S_LADJ   = 4'd5;
  localparam logic [3:0] S_STEP   = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_MUL7   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state, state_next;
  logic       dir_back;
  logic       out_load;

  assign in_ready      = (state == S_IDLE);
  assign out_load      = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next    = state;
    ctrl.op       = OP_NONE;
    ctrl.dir_back = dir_back;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_LOAD: begin
              ctrl.op    = OP_CAP_LOAD;
              state_next = S_LMUL;
            end
            CMD_FWD, CMD_BACK: begin
              ctrl.op    = OP_CAP_STEP;
              state_next = S_STEP;
            end
            default: begin
              ctrl.op    = OP_CAP_NONE;
              state_next = S_SUM;
            end
          endcase
        end
      end
      S_LMUL: begin
        ctrl.op    = OP_YR_MUL;
        state_next = S_LSPLIT;
      end
      S_LSPLIT: begin
        ctrl.op    = OP_YR_SPLIT;
        state_next = S_LMON;
      end
      S_LMON: begin
        ctrl.op    = OP_MON_ADJ;
        state_next = S_LDAY;
      end
      S_LDAY: begin
        ctrl.op    = OP_DAY_SET;
        state_next = S_LADJ;
      end
      S_LADJ: begin
        ctrl.op    = OP_DAY_ADJ;
        state_next = S_SUM;
      end
      S_STEP: begin
        // one day per cycle until the count runs out or a bound stops it
        ctrl.op = OP_STEP;
        if (days_zero) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        ctrl.op    = OP_SUM;
        state_next = S_MUL7;
      end
      S_MUL7: begin
        ctrl.op    = OP_MUL7;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          ctrl.op    = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dir_back  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        dir_back <= (command == CMD_BACK);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
